// ===== rtl/wto_pkg.sv =====
`default_nettype none

package wto_pkg;

    // input request fields
    localparam int CMD_W      = 2;
    localparam int TA_W       = 10;
    localparam int TV_W       = 16;
    localparam int FREQ_W     = 32;
    localparam int TA_LSB     = 0;
    localparam int TV_LSB     = TA_LSB + TA_W;
    localparam int FREQ_LSB   = TV_LSB + TV_W;
    localparam int IN_TDATA_W = ((FREQ_LSB + FREQ_W + 7) / 8) * 8;

    localparam int PHASE_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SOR    = 2'd0,
        REG_START  = 2'd1,
        REG_INTERP = 2'd2
    } t_reg;

endpackage

`default_nettype wire

// ===== rtl/wto_ram.sv =====
`default_nettype none

module wto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/wavetable_oscillator.sv =====
// Pipeline: a tick request accepted on s_axis passes the multiply, increment sum,
// table read, interpolation multiply and output registers to m_axis_tvalid.
// Throughput: one request per cycle while the skid slot is free; phase add and
// paired table read share one stage, so ticks follow back to back. Loads and
// restarts give no result. Reset (synchronous, active low) clears phase, pipeline
// and output valids; registers load size_over_rate 0, start_phase 0, interpolate 1.
`default_nettype none

module wavetable_oscillator #(
    parameter int TABLE_SIZE   = 1024,
    parameter int SAMPLE_WIDTH = 16,
    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: table_address[9:0], table_value[25:10], frequency[57:26], zero pad
    input  logic [wto_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: command[1:0]
    input  logic [wto_pkg::CMD_W-1:0]           s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: sample[SAMPLE_WIDTH-1:0], zero pad
    output logic [OUT_W-1:0]                    m_axis_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wto_pkg::PADDR_W-1:0]         paddr,
    input  logic [wto_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wto_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IB   = $clog2(TABLE_SIZE);
    localparam int FB   = wto_pkg::PHASE_W - IB;
    localparam int AEXT = (IB > wto_pkg::TA_W) ? IB : wto_pkg::TA_W;
    localparam int TV_W = wto_pkg::TV_W;
    localparam int PP_W = wto_pkg::FREQ_W + 17;
    localparam int PROD_W = FB + 18;
    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAMPLE_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    // ---------------- configuration ----------------
    logic [31:0] r_sor;
    logic [31:0] r_start;
    logic        r_interp;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sor    <= 32'd0;
            r_start  <= 32'd0;
            r_interp <= 1'b1;
        end else if (cfg_we) begin
            case (paddr[3:2])
                wto_pkg::REG_SOR:    r_sor    <= pwdata;
                wto_pkg::REG_START:  r_start  <= pwdata;
                wto_pkg::REG_INTERP: r_interp <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            wto_pkg::REG_SOR:    prdata = r_sor;
            wto_pkg::REG_START:  prdata = r_start;
            wto_pkg::REG_INTERP: prdata = {31'd0, r_interp};
            default:             prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic r_skid_valid;

    // whole pipe moves while the skid slot is free
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    // ---------------- stage 1: increment partial products ----------------
    logic [wto_pkg::TA_W-1:0]       in_addr;
    logic [TV_W-1:0]                in_value;
    logic [wto_pkg::FREQ_W-1:0]     in_freq;
    logic signed [PP_W-1:0]         w_pp_lo;
    logic signed [PP_W-1:0]         w_pp_hi;

    assign in_addr  = s_axis_tdata[wto_pkg::TA_LSB +: wto_pkg::TA_W];
    assign in_value = s_axis_tdata[wto_pkg::TV_LSB +: TV_W];
    assign in_freq  = s_axis_tdata[wto_pkg::FREQ_LSB +: wto_pkg::FREQ_W];
    assign w_pp_lo  = PP_W'($signed(in_freq)) * PP_W'($signed({1'b0, r_sor[15:0]}));
    assign w_pp_hi  = PP_W'($signed(in_freq)) * PP_W'($signed({1'b0, r_sor[31:16]}));

    logic                       r1_valid;
    wto_pkg::t_cmd              r1_cmd;
    logic [wto_pkg::TA_W-1:0]   r1_addr;
    logic [TV_W-1:0]            r1_value;
    logic signed [PP_W-1:0]     r1_pp_lo;
    logic signed [PP_W-1:0]     r1_pp_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd   <= wto_pkg::t_cmd'(s_axis_tuser);
            r1_addr  <= in_addr;
            r1_value <= in_value;
            r1_pp_lo <= w_pp_lo;
            r1_pp_hi <= w_pp_hi;
        end
    end

    // ---------------- stage 2: increment, floor-shifted by index bits ----------------
    logic signed [63:0] w_sum;

    assign w_sum = 64'(r1_pp_lo) + (64'(r1_pp_hi) <<< 16);

    logic                       r2_valid;
    wto_pkg::t_cmd              r2_cmd;
    logic [wto_pkg::TA_W-1:0]   r2_addr;
    logic [TV_W-1:0]            r2_value;
    logic [31:0]                r2_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd   <= r1_cmd;
            r2_addr  <= r1_addr;
            r2_value <= r1_value;
            r2_inc   <= w_sum[IB+31:IB];
        end
    end

    // ---------------- stage 3: phase update and table access ----------------
    // Loads and reads are issued in request order from this one stage, so a
    // tick always sees every earlier load.
    logic [31:0]     r_phase;
    logic [AEXT-1:0] w_addr_ext;
    logic [IB-1:0]   w_waddr;
    logic [IB-1:0]   w_idx;
    logic [IB-1:0]   w_nxt;
    logic            w_we;
    logic [TV_W-1:0] rd_a;
    logic [TV_W-1:0] rd_b;

    assign w_addr_ext = AEXT'(r2_addr);
    assign w_waddr    = w_addr_ext[IB-1:0];
    assign w_idx      = r_phase[31 -: IB];
    assign w_nxt      = w_idx + IB'(1);
    assign w_we       = en && r2_valid && (r2_cmd == wto_pkg::CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 32'd0;
        end else if (en && r2_valid) begin
            case (r2_cmd)
                wto_pkg::CMD_RESTART: r_phase <= r_start;
                wto_pkg::CMD_TICK:    r_phase <= r_phase + r2_inc;
                default: ;
            endcase
        end
    end

    wto_ram #(
        .WIDTH (TV_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r2_value),
        .i_re    (en),
        .i_raddr (w_idx),
        .o_rdata (rd_a)
    );

    // copy of the table for the neighbouring entry
    wto_ram #(
        .WIDTH (TV_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r2_value),
        .i_re    (en),
        .i_raddr (w_nxt),
        .o_rdata (rd_b)
    );

    logic          r3_valid;
    logic [FB-1:0] r3_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid && (r2_cmd == wto_pkg::CMD_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_frac <= r_phase[FB-1:0];
        end
    end

    // ---------------- stage 4: (b - a) * frac ----------------
    logic signed [16:0]   w_diff;
    logic signed [FB+17:0] w_prod;

    assign w_diff = $signed({rd_b[TV_W-1], rd_b}) - $signed({rd_a[TV_W-1], rd_a});
    assign w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, r3_frac}));

    logic                  r4_valid;
    logic [TV_W-1:0]       r4_a;
    logic signed [FB+17:0] r4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_a    <= rd_a;
            r4_prod <= w_prod;
        end
    end

    // ---------------- stage 5: sum, saturate, output skid ----------------
    logic signed [16:0]   w_slice;
    logic signed [17:0]   w_val;
    logic signed [32:0]   w_val_ext;
    logic [SAMPLE_WIDTH-1:0] w_sample;

    // floor division by 2^FB is the bit slice of the two's complement product
    assign w_slice   = $signed(r4_prod[FB+16:FB]);
    assign w_val     = $signed({r4_a[TV_W-1], r4_a[TV_W-1], r4_a})
                     + (r_interp ? $signed({w_slice[16], w_slice}) : 18'sd0);
    assign w_val_ext = 33'(w_val);

    always_comb begin
        if (w_val_ext > SAT_HI) begin
            w_sample = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (w_val_ext < SAT_LO) begin
            w_sample = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            w_sample = w_val_ext[SAMPLE_WIDTH-1:0];
        end
    end

    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_sample;
    logic [SAMPLE_WIDTH-1:0] r_skid_sample;
    logic                    n_out_valid;
    logic                    n_skid_valid;
    logic [SAMPLE_WIDTH-1:0] n_out_sample;
    logic [SAMPLE_WIDTH-1:0] n_skid_sample;
    logic                    take;
    logic                    push;

    assign take = r_out_valid && m_axis_tready;
    assign push = r4_valid && en;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        n_out_sample  = r_out_sample;
        n_skid_sample = r_skid_sample;
        if (take) begin
            if (r_skid_valid) begin
                n_out_sample = r_skid_sample;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        // push only happens with the skid slot empty
        if (push) begin
            if (!r_out_valid || take) begin
                n_out_sample = w_sample;
                n_out_valid  = 1'b1;
            end else begin
                n_skid_sample = w_sample;
                n_skid_valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample  <= n_out_sample;
        r_skid_sample <= n_skid_sample;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_sample);

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full with output register empty");

    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(en && r2_valid) |=> $stable(r_phase))
        else $error("phase moved without a tick or restart");

    a_tick_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r2_valid && (r2_cmd == wto_pkg::CMD_TICK)) |=> r3_valid)
        else $error("tick lost at table read stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r_skid_valid) |=> (r4_valid && $stable(r4_prod)))
        else $error("stalled interpolation stage changed");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_skid_valid) |=> r_skid_valid)
        else $error("skid slot dropped while output stalled");
`endif

endmodule

`default_nettype wire
